// ===== hdl/ipnc_pkg.sv =====
// ipnc_pkg: shared types and constants for the ip name cache
// entry and result records, function and status codes, controller states
// no dependencies
package ipnc_pkg;

    localparam int KEY_W   = 16;
    localparam int ADDR_W  = 32;
    localparam int NAME_W  = 16;
    localparam int TTL_W   = 16;
    localparam int COUNT_W = 12;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [1:0] {
        FN_INSERT = 2'd0,
        FN_LOOKUP = 2'd1,
        FN_TICK   = 2'd2
    } func_t;

    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_UPDATED  = 3'd1,
        ST_FULL     = 3'd2,
        ST_HIT      = 3'd3,
        ST_MISS     = 3'd4,
        ST_TICK     = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_INDEX,
        S_READ,
        S_UPDATE,
        S_SWEEP,
        S_FLUSH
    } state_t;

    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] addr;
        logic [NAME_W-1:0] name;
        logic [TTL_W-1:0]  ttl;
    } entry_t;

    typedef struct packed {
        status_t           status;
        logic [NAME_W-1:0] name;
        logic [TTL_W-1:0]  ttl;
    } res_t;

endpackage

// ===== hdl/ip_name_cache_with_ttl_aging_unit.sv =====
// ip_name_cache_with_ttl_aging_unit: top level of the ip address to name cache
// controller, bucket map, row memory and row logic
// depends on ipnc_pkg, ipnc_bucket_map, ipnc_row_ram, ipnc_row_logic
//
// After reset the block sweeps the row memory to clear every valid flag and
// holds s_ready low meanwhile. Each bucket is one memory row of WAYS entries,
// so insert and lookup go through these steps per item: the accept cycle,
// which also starts the two-stage key-to-bucket multiply, the second multiply
// stage, then a read and a modify-and-write step on the row memory, which has
// one read port and one write port. An aging tick reads and writes back every
// row once through the same memory. Items with function code 3 are taken and
// dropped with no result. One item is worked on at a time; the result register
// lets the next item in while the previous result still waits on m_ready, and
// the final write step of that next item waits until the result register is
// free.
module ip_name_cache_with_ttl_aging_unit #(
    parameter int BUCKETS = 512,
    parameter int WAYS    = 4
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [1:0]                          s_func,
    input  logic [ipnc_pkg::ADDR_W-1:0]         s_ip_addr,
    input  logic [ipnc_pkg::NAME_W-1:0]         s_name_handle,
    input  logic [ipnc_pkg::TTL_W-1:0]          s_ttl_in,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [2:0]                          m_status,
    output logic [ipnc_pkg::NAME_W-1:0]         m_name_out,
    output logic [ipnc_pkg::TTL_W-1:0]          m_ttl_left,
    output logic [ipnc_pkg::COUNT_W-1:0]        m_expired_count
);

    localparam int BIDX_W = $clog2(BUCKETS);
    localparam int CNT_W  = $clog2(WAYS + 1);
    localparam logic [BIDX_W-1:0] LAST_ROW = BIDX_W'(BUCKETS - 1);

    ipnc_pkg::state_t                  state_reg, state_next;
    ipnc_pkg::func_t                   func_reg, func_next;
    logic [ipnc_pkg::ADDR_W-1:0]       addr_reg, addr_next;
    logic [ipnc_pkg::NAME_W-1:0]       name_reg, name_next;
    logic [ipnc_pkg::TTL_W-1:0]        ttl_reg, ttl_next;
    logic [BIDX_W-1:0]                 row_addr_reg, row_addr_next;
    logic [BIDX_W-1:0]                 wb_addr_reg, wb_addr_next;
    logic                              wb_pending_reg, wb_pending_next;
    logic [ipnc_pkg::COUNT_W-1:0]      count_reg, count_next;

    logic                              m_valid_reg, m_valid_next;
    ipnc_pkg::res_t                    m_res_reg, m_res_next;
    logic [ipnc_pkg::COUNT_W-1:0]      m_count_reg, m_count_next;

    logic [BIDX_W-1:0]                 bucket_idx;
    logic                              mem_we, mem_re;
    logic [BIDX_W-1:0]                 mem_waddr, mem_raddr;
    ipnc_pkg::entry_t [WAYS-1:0]       mem_wdata, mem_rdata, row_out;
    logic                              row_we;
    ipnc_pkg::res_t                    row_res;
    logic [CNT_W-1:0]                  freed;

    logic                              accept;
    logic                              out_free;
    logic                              last_row;
    logic                              load_out;
    logic [ipnc_pkg::COUNT_W:0]        count_sum;
    logic [ipnc_pkg::COUNT_W-1:0]      count_sat;

    ipnc_bucket_map #(
        .BUCKETS (BUCKETS),
        .BIDX_W  (BIDX_W)
    ) u_bucket_map (
        .aclk   (aclk),
        .key    (s_ip_addr[ipnc_pkg::KEY_W-1:0]),
        .bucket (bucket_idx)
    );

    ipnc_row_ram #(
        .DEPTH (BUCKETS),
        .AW    (BIDX_W),
        .WAYS  (WAYS)
    ) u_row_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    ipnc_row_logic #(
        .WAYS  (WAYS),
        .CNT_W (CNT_W)
    ) u_row_logic (
        .func        (func_reg),
        .ip_addr     (addr_reg),
        .name_handle (name_reg),
        .ttl_in      (ttl_reg),
        .row_in      (mem_rdata),
        .row_out     (row_out),
        .row_we      (row_we),
        .res         (row_res),
        .freed       (freed)
    );

    assign accept    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign last_row  = (row_addr_reg == LAST_ROW);
    assign count_sum = (ipnc_pkg::COUNT_W + 1)'(count_reg) + (ipnc_pkg::COUNT_W + 1)'(freed);
    assign count_sat = count_sum[ipnc_pkg::COUNT_W] ? ipnc_pkg::COUNT_MAX
                                                    : count_sum[ipnc_pkg::COUNT_W-1:0];

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ipnc_pkg::S_CLEAR: begin
                if (last_row) begin
                    state_next = ipnc_pkg::S_IDLE;
                end
            end
            ipnc_pkg::S_IDLE: begin
                if (s_valid) begin
                    case (ipnc_pkg::func_t'(s_func))
                        ipnc_pkg::FN_INSERT: state_next = ipnc_pkg::S_INDEX;
                        ipnc_pkg::FN_LOOKUP: state_next = ipnc_pkg::S_INDEX;
                        ipnc_pkg::FN_TICK:   state_next = ipnc_pkg::S_SWEEP;
                        default:             state_next = ipnc_pkg::S_IDLE;
                    endcase
                end
            end
            ipnc_pkg::S_INDEX: state_next = ipnc_pkg::S_READ;
            ipnc_pkg::S_READ:  state_next = ipnc_pkg::S_UPDATE;
            ipnc_pkg::S_UPDATE: begin
                if (out_free) begin
                    state_next = ipnc_pkg::S_IDLE;
                end
            end
            ipnc_pkg::S_SWEEP: begin
                if (last_row) begin
                    state_next = ipnc_pkg::S_FLUSH;
                end
            end
            ipnc_pkg::S_FLUSH: begin
                if (out_free) begin
                    state_next = ipnc_pkg::S_IDLE;
                end
            end
            default: state_next = ipnc_pkg::S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_ready   = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = row_addr_reg;
        mem_wdata = row_out;
        mem_re    = 1'b0;
        mem_raddr = row_addr_reg;
        load_out  = 1'b0;
        case (state_reg)
            ipnc_pkg::S_CLEAR: begin
                mem_we    = 1'b1;
                mem_wdata = '0;
            end
            ipnc_pkg::S_IDLE: begin
                s_ready = 1'b1;
            end
            ipnc_pkg::S_READ: begin
                mem_re    = 1'b1;
                mem_raddr = bucket_idx;
            end
            ipnc_pkg::S_UPDATE: begin
                if (out_free) begin
                    mem_we   = row_we;
                    load_out = 1'b1;
                end
            end
            ipnc_pkg::S_SWEEP: begin
                mem_re    = 1'b1;
                mem_we    = wb_pending_reg;
                mem_waddr = wb_addr_reg;
            end
            ipnc_pkg::S_FLUSH: begin
                mem_waddr = wb_addr_reg;
                if (out_free) begin
                    mem_we   = 1'b1;
                    load_out = 1'b1;
                end
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // datapath registers
    always_comb begin
        func_next       = func_reg;
        addr_next       = addr_reg;
        name_next       = name_reg;
        ttl_next        = ttl_reg;
        row_addr_next   = row_addr_reg;
        wb_addr_next    = wb_addr_reg;
        wb_pending_next = wb_pending_reg;
        count_next      = count_reg;
        case (state_reg)
            ipnc_pkg::S_CLEAR: begin
                row_addr_next = last_row ? '0 : row_addr_reg + 1'b1;
            end
            ipnc_pkg::S_IDLE: begin
                if (accept) begin
                    func_next = ipnc_pkg::func_t'(s_func);
                    addr_next = s_ip_addr;
                    name_next = s_name_handle;
                    ttl_next  = s_ttl_in;
                end
                row_addr_next   = '0;
                wb_pending_next = 1'b0;
                count_next      = '0;
            end
            ipnc_pkg::S_READ: begin
                row_addr_next = bucket_idx;
            end
            ipnc_pkg::S_SWEEP: begin
                wb_addr_next    = row_addr_reg;
                wb_pending_next = 1'b1;
                if (!last_row) begin
                    row_addr_next = row_addr_reg + 1'b1;
                end
                if (wb_pending_reg) begin
                    count_next = count_sat;
                end
            end
            default: begin
                count_next = count_reg;
            end
        endcase
    end

    // result register
    always_comb begin
        m_valid_next = m_valid_reg;
        m_res_next   = m_res_reg;
        m_count_next = m_count_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (load_out) begin
            m_valid_next = 1'b1;
            m_res_next   = row_res;
            m_count_next = (state_reg == ipnc_pkg::S_FLUSH) ? count_sat : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ipnc_pkg::S_CLEAR;
            row_addr_reg   <= '0;
            wb_pending_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            row_addr_reg   <= row_addr_next;
            wb_pending_reg <= wb_pending_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg    <= func_next;
        addr_reg    <= addr_next;
        name_reg    <= name_next;
        ttl_reg     <= ttl_next;
        wb_addr_reg <= wb_addr_next;
        count_reg   <= count_next;
        m_res_reg   <= m_res_next;
        m_count_reg <= m_count_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_res_reg.status;
    assign m_name_out      = m_res_reg.name;
    assign m_ttl_left      = m_res_reg.ttl;
    assign m_expired_count = m_count_reg;

    a_no_same_row_rw: assert property (@(posedge aclk) disable iff (!aresetn)
        (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
        else $error("row read and written in the same cycle");

    a_load_only_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |-> out_free)
        else $error("result loaded over an untaken item");

    a_count_only_on_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_expired_count == '0) || (m_status == ipnc_pkg::ST_TICK)))
        else $error("expired count on a non-tick result");

    a_payload_only_on_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status != ipnc_pkg::ST_HIT)) |->
        ((m_name_out == '0) && (m_ttl_left == '0)))
        else $error("name or ttl on a non-hit result");

    a_count_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ipnc_pkg::S_SWEEP) && ($past(state_reg) == ipnc_pkg::S_SWEEP))
        |-> (count_reg >= $past(count_reg)))
        else $error("expired count fell during a sweep");

endmodule

// ===== hdl/ipnc_bucket_map.sv =====
// ipnc_bucket_map: two-stage key to bucket reduction, key mod BUCKETS
// reciprocal multiply then multiply-subtract for the remainder
// depends on ipnc_pkg
module ipnc_bucket_map #(
    parameter int BUCKETS = 512,
    parameter int BIDX_W  = 9
) (
    input  logic                         aclk,
    input  logic [ipnc_pkg::KEY_W-1:0]   key,
    output logic [BIDX_W-1:0]            bucket
);

    localparam logic [63:0] RECIP_W =
        ((64'd1 << 32) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);
    localparam logic [31:0] RECIP = RECIP_W[31:0];
    localparam logic [16:0] BUCKETS_C = 17'(BUCKETS);

    logic [47:0]                  prod_reg;
    logic [ipnc_pkg::KEY_W-1:0]   key_d_reg;
    logic [BIDX_W-1:0]            bucket_reg;
    logic [15:0]                  quot;
    logic [32:0]                  qb;
    logic [32:0]                  rem_full;

    // quotient is exact for a 16 bit key with a rounded-up reciprocal
    assign quot     = prod_reg[47:32];
    assign qb       = 33'(quot) * 33'(BUCKETS_C);
    assign rem_full = 33'(key_d_reg) - qb;

    always_ff @(posedge aclk) begin
        prod_reg   <= 48'(key) * 48'(RECIP);
        key_d_reg  <= key;
        bucket_reg <= rem_full[BIDX_W-1:0];
    end

    assign bucket = bucket_reg;

endmodule

// ===== hdl/ipnc_row_ram.sv =====
// ipnc_row_ram: one bucket row per address, WAYS entries wide
// single write port, single registered read port
// depends on ipnc_pkg
module ipnc_row_ram #(
    parameter int DEPTH = 512,
    parameter int AW    = 9,
    parameter int WAYS  = 4
) (
    input  logic                              aclk,
    input  logic                              we,
    input  logic [AW-1:0]                     waddr,
    input  ipnc_pkg::entry_t [WAYS-1:0]       wdata,
    input  logic                              re,
    input  logic [AW-1:0]                     raddr,
    output ipnc_pkg::entry_t [WAYS-1:0]       rdata
);

    ipnc_pkg::entry_t [WAYS-1:0] mem [DEPTH];
    ipnc_pkg::entry_t [WAYS-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/ipnc_row_logic.sv =====
// ipnc_row_logic: modify one fetched bucket row for insert, lookup or aging
// way match, lowest free way, per-way ttl countdown
// depends on ipnc_pkg
module ipnc_row_logic #(
    parameter int WAYS  = 4,
    parameter int CNT_W = 3
) (
    input  ipnc_pkg::func_t                   func,
    input  logic [ipnc_pkg::ADDR_W-1:0]       ip_addr,
    input  logic [ipnc_pkg::NAME_W-1:0]       name_handle,
    input  logic [ipnc_pkg::TTL_W-1:0]        ttl_in,
    input  ipnc_pkg::entry_t [WAYS-1:0]       row_in,
    output ipnc_pkg::entry_t [WAYS-1:0]       row_out,
    output logic                              row_we,
    output ipnc_pkg::res_t                    res,
    output logic [CNT_W-1:0]                  freed
);

    localparam int WIDX_W = (WAYS > 1) ? $clog2(WAYS) : 1;

    logic              hit;
    logic [WIDX_W-1:0] hit_idx;
    logic              has_free;
    logic [WIDX_W-1:0] free_idx;
    logic [WAYS-1:0]   expire_mask;

    always_comb begin
        hit      = 1'b0;
        hit_idx  = '0;
        has_free = 1'b0;
        free_idx = '0;
        // descending so the lowest way wins
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (row_in[w].valid && (row_in[w].addr == ip_addr)) begin
                hit     = 1'b1;
                hit_idx = WIDX_W'(w);
            end
            if (!row_in[w].valid) begin
                has_free = 1'b1;
                free_idx = WIDX_W'(w);
            end
        end
    end

    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            expire_mask[w] = row_in[w].valid && (row_in[w].ttl == '0);
        end
    end

    always_comb begin
        row_out    = row_in;
        row_we     = 1'b0;
        res.status = ipnc_pkg::ST_MISS;
        res.name   = '0;
        res.ttl    = '0;
        freed      = '0;
        case (func)
            ipnc_pkg::FN_INSERT: begin
                if (hit) begin
                    row_out[hit_idx].name = name_handle;
                    row_out[hit_idx].ttl  = ttl_in;
                    row_we                = 1'b1;
                    res.status            = ipnc_pkg::ST_UPDATED;
                end else if (has_free) begin
                    row_out[free_idx].valid = 1'b1;
                    row_out[free_idx].addr  = ip_addr;
                    row_out[free_idx].name  = name_handle;
                    row_out[free_idx].ttl   = ttl_in;
                    row_we                  = 1'b1;
                    res.status              = ipnc_pkg::ST_INSERTED;
                end else begin
                    res.status = ipnc_pkg::ST_FULL;
                end
            end
            ipnc_pkg::FN_LOOKUP: begin
                if (hit) begin
                    res.status = ipnc_pkg::ST_HIT;
                    res.name   = row_in[hit_idx].name;
                    res.ttl    = row_in[hit_idx].ttl;
                end
            end
            ipnc_pkg::FN_TICK: begin
                for (int w = 0; w < WAYS; w++) begin
                    if (expire_mask[w]) begin
                        row_out[w].valid = 1'b0;
                    end else if (row_in[w].valid) begin
                        row_out[w].ttl = row_in[w].ttl - 16'd1;
                    end
                end
                row_we     = 1'b1;
                res.status = ipnc_pkg::ST_TICK;
                freed      = CNT_W'($countones(expire_mask));
            end
            default: begin
                row_we = 1'b0;
            end
        endcase
    end

endmodule

// ===== tb/ipnc_cache_checker.sv =====
// ipnc_cache_checker: watches both channels of the ip name cache, keeps its own
// copy of the bucketed table and compares every result item with the prediction
// depends on ipnc_pkg
module ipnc_cache_checker #(
    parameter int BUCKETS = 512,
    parameter int WAYS    = 4
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  logic [1:0]                      s_func,
    input  logic [ipnc_pkg::ADDR_W-1:0]     s_ip_addr,
    input  logic [ipnc_pkg::NAME_W-1:0]     s_name_handle,
    input  logic [ipnc_pkg::TTL_W-1:0]      s_ttl_in,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  logic [2:0]                      m_status,
    input  logic [ipnc_pkg::NAME_W-1:0]     m_name_out,
    input  logic [ipnc_pkg::TTL_W-1:0]      m_ttl_left,
    input  logic [ipnc_pkg::COUNT_W-1:0]    m_expired_count,
    output int                              mismatch_count,
    output int                              results_owed
);

    localparam int ENTRIES    = BUCKETS * WAYS;
    localparam int REPORT_MAX = 10;

    typedef struct {
        ipnc_pkg::status_t            status;
        logic [ipnc_pkg::NAME_W-1:0]  name;
        logic [ipnc_pkg::TTL_W-1:0]   ttl;
        logic [ipnc_pkg::COUNT_W-1:0] expired;
    } cache_result_t;

    logic                        slot_valid [ENTRIES];
    logic [ipnc_pkg::ADDR_W-1:0] slot_addr  [ENTRIES];
    logic [ipnc_pkg::NAME_W-1:0] slot_name  [ENTRIES];
    logic [ipnc_pkg::TTL_W-1:0]  slot_ttl   [ENTRIES];

    cache_result_t awaited_results [$];
    cache_result_t want;
    int            fails = 0;

    initial begin
        for (int i = 0; i < ENTRIES; i++) begin
            slot_valid[i] = 1'b0;
            slot_addr[i]  = '0;
            slot_name[i]  = '0;
            slot_ttl[i]   = '0;
        end
    end

    function automatic int bucket_first_slot(input logic [ipnc_pkg::ADDR_W-1:0] key);
        return (int'(key[ipnc_pkg::KEY_W-1:0]) % BUCKETS) * WAYS;
    endfunction

    function automatic int find_slot(input logic [ipnc_pkg::ADDR_W-1:0] key);
        int first;
        first = bucket_first_slot(key);
        for (int w = 0; w < WAYS; w++) begin
            if (slot_valid[first + w] && slot_addr[first + w] == key) begin
                return first + w;
            end
        end
        return -1;
    endfunction

    function automatic void predict_cache_op(
        input logic [1:0]                  fn,
        input logic [ipnc_pkg::ADDR_W-1:0] key,
        input logic [ipnc_pkg::NAME_W-1:0] handle,
        input logic [ipnc_pkg::TTL_W-1:0]  ttl
    );
        cache_result_t r;
        int            slot;
        int            first;
        r.status  = ipnc_pkg::ST_TICK;
        r.name    = '0;
        r.ttl     = '0;
        r.expired = '0;
        case (fn)
            ipnc_pkg::FN_INSERT: begin
                slot = find_slot(key);
                if (slot >= 0) begin
                    slot_name[slot] = handle;
                    slot_ttl[slot]  = ttl;
                    r.status = ipnc_pkg::ST_UPDATED;
                end else begin
                    first    = bucket_first_slot(key);
                    r.status = ipnc_pkg::ST_FULL;
                    for (int w = 0; w < WAYS; w++) begin
                        if (!slot_valid[first + w]) begin
                            slot_valid[first + w] = 1'b1;
                            slot_addr[first + w]  = key;
                            slot_name[first + w]  = handle;
                            slot_ttl[first + w]   = ttl;
                            r.status = ipnc_pkg::ST_INSERTED;
                            break;
                        end
                    end
                end
            end
            ipnc_pkg::FN_LOOKUP: begin
                slot = find_slot(key);
                if (slot >= 0) begin
                    r.status = ipnc_pkg::ST_HIT;
                    r.name   = slot_name[slot];
                    r.ttl    = slot_ttl[slot];
                end else begin
                    r.status = ipnc_pkg::ST_MISS;
                end
            end
            ipnc_pkg::FN_TICK: begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (slot_valid[i]) begin
                        if (slot_ttl[i] == '0) begin
                            slot_valid[i] = 1'b0;
                            if (r.expired != ipnc_pkg::COUNT_MAX) begin
                                r.expired = r.expired + 1'b1;
                            end
                        end else begin
                            slot_ttl[i] = slot_ttl[i] - 1'b1;
                        end
                    end
                end
            end
            default: begin
                return;
            end
        endcase
        awaited_results.push_back(r);
    endfunction

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (awaited_results.size() == 0) begin
                    fails++;
                    if (fails <= REPORT_MAX) begin
                        $display("unexpected result item: status %0d name %h ttl %h",
                                 m_status, m_name_out, m_ttl_left);
                        $display("    expired %0d", m_expired_count);
                    end
                end else begin
                    want = awaited_results.pop_front();
                    if (m_status !== want.status || m_name_out !== want.name ||
                        m_ttl_left !== want.ttl || m_expired_count !== want.expired) begin
                        fails++;
                        if (fails <= REPORT_MAX) begin
                            $display("result mismatch: status %0d/%0d name %h/%h",
                                     want.status, m_status, want.name, m_name_out);
                            $display("    ttl %h/%h expired %0d/%0d",
                                     want.ttl, m_ttl_left, want.expired, m_expired_count);
                        end
                    end
                end
            end
            if (s_valid && s_ready) begin
                predict_cache_op(s_func, s_ip_addr, s_name_handle, s_ttl_in);
            end
        end
        mismatch_count <= fails;
        results_owed   <= awaited_results.size();
    end

endmodule

// ===== tb/tb_ip_name_cache_with_ttl_aging_unit.sv =====
// tb_ip_name_cache_with_ttl_aging_unit: drives directed and random cache requests
// with random gaps and stalls into the cache and gives the verdict
// depends on ipnc_pkg, ip_name_cache_with_ttl_aging_unit, ipnc_cache_checker
module tb_ip_name_cache_with_ttl_aging_unit;

    localparam int         BUCKETS      = 512;
    localparam int         WAYS         = 4;
    localparam logic [1:0] FN_UNUSED    = 2'd3;
    localparam int         RANDOM_ITEMS = 600;
    localparam int         POOL_SIZE    = 48;
    localparam int         HOT_BUCKETS  = 6;
    localparam int         MAX_WAIT     = 11;
    localparam int         LONG_HOLD    = 300;
    localparam int         DRAIN_CYCLES = BUCKETS + 100;
    localparam int         CYCLE_LIMIT  = 1_500_000;

    logic                          aclk;
    logic                          aresetn       = 1'b0;
    logic                          s_valid       = 1'b0;
    logic [1:0]                    s_func        = '0;
    logic [ipnc_pkg::ADDR_W-1:0]   s_ip_addr     = '0;
    logic [ipnc_pkg::NAME_W-1:0]   s_name_handle = '0;
    logic [ipnc_pkg::TTL_W-1:0]    s_ttl_in      = '0;
    logic                          m_ready       = 1'b0;
    logic                          s_ready;
    logic                          m_valid;
    logic [2:0]                    m_status;
    logic [ipnc_pkg::NAME_W-1:0]   m_name_out;
    logic [ipnc_pkg::TTL_W-1:0]    m_ttl_left;
    logic [ipnc_pkg::COUNT_W-1:0]  m_expired_count;

    int                            mismatch_count;
    int                            results_owed;
    int                            cycle_count     = 0;
    bit                            sender_bursty   = 1'b0;
    bit                            receiver_bursty = 1'b0;
    logic [ipnc_pkg::ADDR_W-1:0]   addr_pool [POOL_SIZE];

    ip_name_cache_with_ttl_aging_unit #(
        .BUCKETS (BUCKETS),
        .WAYS    (WAYS)
    ) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_func          (s_func),
        .s_ip_addr       (s_ip_addr),
        .s_name_handle   (s_name_handle),
        .s_ttl_in        (s_ttl_in),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_name_out      (m_name_out),
        .m_ttl_left      (m_ttl_left),
        .m_expired_count (m_expired_count)
    );

    ipnc_cache_checker #(
        .BUCKETS (BUCKETS),
        .WAYS    (WAYS)
    ) checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_func          (s_func),
        .s_ip_addr       (s_ip_addr),
        .s_name_handle   (s_name_handle),
        .s_ttl_in        (s_ttl_in),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_name_out      (m_name_out),
        .m_ttl_left      (m_ttl_left),
        .m_expired_count (m_expired_count),
        .mismatch_count  (mismatch_count),
        .results_owed    (results_owed)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic offer_request(
        input logic [1:0]                  fn,
        input logic [ipnc_pkg::ADDR_W-1:0] key,
        input logic [ipnc_pkg::NAME_W-1:0] handle,
        input logic [ipnc_pkg::TTL_W-1:0]  ttl
    );
        int gap;
        gap = sender_bursty ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_func        <= fn;
        s_ip_addr     <= key;
        s_name_handle <= handle;
        s_ttl_in      <= ttl;
        do @(posedge aclk); while (!(s_valid && s_ready));
    endtask

    // result side: random stalls, a few long hold-offs to back up the input
    initial begin
        int wait_cycles;
        int taken;
        taken = 0;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (taken == 150 || taken == 420) begin
                wait_cycles = LONG_HOLD;
            end else begin
                wait_cycles = receiver_bursty ? 0 : $urandom_range(0, MAX_WAIT);
            end
            if (wait_cycles > 0) begin
                m_ready <= 1'b0;
                repeat (wait_cycles) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
            taken++;
            if ($urandom_range(0, 29) == 0) begin
                receiver_bursty = !receiver_bursty;
            end
        end
    end

    initial begin
        int                          made;
        int                          pick;
        logic [1:0]                  fn;
        logic [ipnc_pkg::ADDR_W-1:0] key;
        logic [ipnc_pkg::TTL_W-1:0]  ttl;

        // a few crowded buckets so that updates, hits and full buckets occur
        for (int i = 0; i < POOL_SIZE; i++) begin
            key      = $urandom();
            key[8:0] = 9'((i % HOT_BUCKETS) * 83 + 7);
            addr_pool[i] = key;
        end

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // one bucket filled to the brim, then the extremes
        offer_request(ipnc_pkg::FN_LOOKUP, 32'h0000_0123, 16'h0000, 16'h0000);
        offer_request(ipnc_pkg::FN_INSERT, 32'h0000_0123, 16'h0000, 16'h0000);
        offer_request(ipnc_pkg::FN_INSERT, 32'hffff_0123, 16'hffff, 16'hffff);
        offer_request(ipnc_pkg::FN_INSERT, 32'h8000_ff23, 16'h1234, 16'h0001);
        offer_request(ipnc_pkg::FN_INSERT, 32'h5a5a_0323, 16'h8000, 16'h0002);
        offer_request(ipnc_pkg::FN_INSERT, 32'h0001_0123, 16'h4321, 16'h0005);
        offer_request(ipnc_pkg::FN_LOOKUP, 32'h0001_0123, 16'h0000, 16'h0000);
        offer_request(ipnc_pkg::FN_LOOKUP, 32'hffff_0123, 16'h0000, 16'h0000);
        offer_request(ipnc_pkg::FN_INSERT, 32'hffff_0123, 16'h00ff, 16'h0003);
        offer_request(ipnc_pkg::FN_LOOKUP, 32'hffff_0123, 16'hffff, 16'hffff);
        offer_request(FN_UNUSED,           32'h0000_0123, 16'hffff, 16'hffff);
        offer_request(ipnc_pkg::FN_TICK,   32'h0000_0000, 16'h0000, 16'h0000);
        offer_request(ipnc_pkg::FN_LOOKUP, 32'h0000_0123, 16'h0000, 16'h0000);
        offer_request(ipnc_pkg::FN_INSERT, 32'h0001_0123, 16'h4321, 16'h0005);
        offer_request(ipnc_pkg::FN_LOOKUP, 32'h8000_ff23, 16'h0000, 16'h0000);
        offer_request(ipnc_pkg::FN_TICK,   32'hffff_ffff, 16'hffff, 16'hffff);
        offer_request(ipnc_pkg::FN_INSERT, 32'hffff_ffff, 16'hffff, 16'hffff);
        offer_request(ipnc_pkg::FN_LOOKUP, 32'hffff_ffff, 16'h0000, 16'h0000);
        offer_request(ipnc_pkg::FN_INSERT, 32'h0000_0000, 16'h0000, 16'h0000);
        offer_request(ipnc_pkg::FN_LOOKUP, 32'h0000_0000, 16'h0000, 16'h0000);
        offer_request(ipnc_pkg::FN_TICK,   32'h0000_0000, 16'h0000, 16'h0000);
        offer_request(ipnc_pkg::FN_LOOKUP, 32'h0000_0000, 16'h0000, 16'h0000);
        offer_request(ipnc_pkg::FN_TICK,   32'h0000_0000, 16'h0000, 16'h0000);

        made = 0;
        while (made < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                fn = ipnc_pkg::FN_TICK;
            end else if (pick < 10) begin
                fn = FN_UNUSED;
            end else if (pick < 55) begin
                fn = ipnc_pkg::FN_INSERT;
            end else begin
                fn = ipnc_pkg::FN_LOOKUP;
            end
            if ($urandom_range(0, 4) == 0) begin
                key = $urandom();
            end else begin
                key = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
            end
            if ($urandom_range(0, 3) == 0) begin
                ttl = 16'($urandom());
            end else begin
                ttl = 16'($urandom_range(0, 4));
            end
            offer_request(fn, key, 16'($urandom()), ttl);
            if (fn != FN_UNUSED) begin
                made++;
            end
            if ($urandom_range(0, 29) == 0) begin
                sender_bursty = !sender_bursty;
            end
        end
        s_valid <= 1'b0;

        @(posedge aclk);
        while (results_owed != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && results_owed == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
